// ===== rtl/iech_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iech_pkg: shared types and constants for the input event classifier
// Event and code numbers, notice kinds, and the structs passed between units.
// ----------------------------------------------------------------------------
package iech_pkg;

	localparam int TOUCH_SLOTS_DEF = 64;

	// event types
	localparam logic [15:0] EVT_SYN = 16'd0;
	localparam logic [15:0] EVT_KEY = 16'd1;
	localparam logic [15:0] EVT_ABS = 16'd3;
	localparam logic [15:0] EVT_SW  = 16'd5;

	// event codes
	localparam logic [15:0] CODE_SYN_REPORT         = 16'h0000;
	localparam logic [15:0] CODE_SW_LID             = 16'h0000;
	localparam logic [15:0] CODE_SW_TABLET          = 16'h0001;
	localparam logic [15:0] CODE_KEY_POWER          = 16'd116;
	localparam logic [15:0] CODE_BTN_TOOL_FINGER    = 16'h0145;
	localparam logic [15:0] CODE_ABS_DISTANCE       = 16'h0019;
	localparam logic [15:0] CODE_ABS_MT_SLOT        = 16'h002f;
	localparam logic [15:0] CODE_ABS_MT_TRACKING_ID = 16'h0039;

	typedef enum logic [1:0] {
		KIND_LID    = 2'd0,
		KIND_TABLET = 2'd1,
		KIND_BUTTON = 2'd2,
		KIND_HOVER  = 2'd3
	} notice_kind_t;

	typedef struct packed {
		logic [15:0]        event_type;
		logic [15:0]        event_code;
		logic signed [31:0] event_value;
		logic               from_power_button;
		logic               from_lid_switch;
		logic               from_tablet_switch;
		logic               from_hover_pad;
	} event_t;

	typedef struct packed {
		logic         hit;
		notice_kind_t kind;
		logic [1:0]   value;
	} notice_t;

endpackage

// ===== rtl/iech_event_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iech_event_if: input event channel
// Valid/ready channel carrying one input event and its source class flags.
// ----------------------------------------------------------------------------
interface iech_event_if;
	logic               valid;
	logic               ready;
	logic [15:0]        event_type;
	logic [15:0]        event_code;
	logic signed [31:0] event_value;
	logic               from_power_button;
	logic               from_lid_switch;
	logic               from_tablet_switch;
	logic               from_hover_pad;

	modport source (
		output valid, event_type, event_code, event_value,
		output from_power_button, from_lid_switch, from_tablet_switch, from_hover_pad,
		input  ready
	);
	modport sink (
		input  valid, event_type, event_code, event_value,
		input  from_power_button, from_lid_switch, from_tablet_switch, from_hover_pad,
		output ready
	);
endinterface

// ===== rtl/iech_notice_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iech_notice_if: notice channel
// Valid/ready channel carrying one notice and the kept switch states.
// ----------------------------------------------------------------------------
interface iech_notice_if;
	logic       valid;
	logic       ready;
	logic [1:0] notice_kind;
	logic [1:0] notice_value;
	logic       lid_closed_now;
	logic       tablet_on_now;

	modport source (
		output valid, notice_kind, notice_value, lid_closed_now, tablet_on_now,
		input  ready
	);
	modport sink (
		input  valid, notice_kind, notice_value, lid_closed_now, tablet_on_now,
		output ready
	);
endinterface

// ===== rtl/iech_switch.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iech_switch: lid, tablet mode and power button decode
// Holds the kept lid and tablet states and flags switch and button notices.
// ----------------------------------------------------------------------------
module iech_switch (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  iech_pkg::event_t  evt,
	output iech_pkg::notice_t notice,
	output logic              lid_now,
	output logic              tablet_now
);

	logic lid_closed_q;
	logic tablet_on_q;
	logic is_one;
	logic lid_hit;
	logic tab_hit;
	logic btn_hit;

	assign is_one  = (evt.event_value == 32'sd1);
	assign lid_hit = evt.from_lid_switch && (evt.event_type == iech_pkg::EVT_SW)
		&& (evt.event_code == iech_pkg::CODE_SW_LID);
	assign tab_hit = evt.from_tablet_switch && (evt.event_type == iech_pkg::EVT_SW)
		&& (evt.event_code == iech_pkg::CODE_SW_TABLET);
	// button value must be 0, 1 or 2
	assign btn_hit = evt.from_power_button && (evt.event_type == iech_pkg::EVT_KEY)
		&& (evt.event_code == iech_pkg::CODE_KEY_POWER)
		&& (evt.event_value[31:2] == 30'd0) && (evt.event_value[1:0] != 2'b11);

	assign lid_now    = lid_hit ? is_one : lid_closed_q;
	assign tablet_now = tab_hit ? is_one : tablet_on_q;

	always_comb begin
		notice.hit   = 1'b0;
		notice.kind  = iech_pkg::KIND_LID;
		notice.value = 2'd0;
		if (lid_hit) begin
			notice.hit   = 1'b1;
			notice.kind  = iech_pkg::KIND_LID;
			notice.value = {1'b0, is_one};
		end else if (tab_hit) begin
			notice.hit   = 1'b1;
			notice.kind  = iech_pkg::KIND_TABLET;
			notice.value = {1'b0, is_one};
		end else if (btn_hit) begin
			notice.hit   = 1'b1;
			notice.kind  = iech_pkg::KIND_BUTTON;
			notice.value = evt.event_value[1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lid_closed_q <= 1'b0;
			tablet_on_q  <= 1'b0;
		end else if (en) begin
			lid_closed_q <= lid_now;
			tablet_on_q  <= tablet_now;
		end
	end

endmodule

// ===== rtl/iech_hover.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iech_hover: hover touchpad tracker
// Tracks the multitouch slot, slot occupancy and single-touch flags, and
// flags a hover notice on report end when the combined state flips.
// ----------------------------------------------------------------------------
module iech_hover #(
	parameter int TOUCH_SLOTS = iech_pkg::TOUCH_SLOTS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  iech_pkg::event_t  evt,
	output iech_pkg::notice_t notice
);

	localparam int SlotW = (TOUCH_SLOTS > 1) ? $clog2(TOUCH_SLOTS) : 1;

	logic [SlotW-1:0]       slot_q;
	logic                   slot_valid_q;
	logic [TOUCH_SLOTS-1:0] mask_q;
	logic                   dist_q;
	logic                   finger_q;
	logic                   hovering_q;

	logic is_abs;
	logic is_slot;
	logic is_track;
	logic is_dist;
	logic is_finger;
	logic is_report;
	logic slot_in_range;
	logic hover_now;

	assign is_abs    = evt.from_hover_pad && (evt.event_type == iech_pkg::EVT_ABS);
	assign is_slot   = is_abs && (evt.event_code == iech_pkg::CODE_ABS_MT_SLOT);
	assign is_track  = is_abs && (evt.event_code == iech_pkg::CODE_ABS_MT_TRACKING_ID);
	assign is_dist   = is_abs && (evt.event_code == iech_pkg::CODE_ABS_DISTANCE);
	assign is_finger = evt.from_hover_pad && (evt.event_type == iech_pkg::EVT_KEY)
		&& (evt.event_code == iech_pkg::CODE_BTN_TOOL_FINGER);
	assign is_report = evt.from_hover_pad && (evt.event_type == iech_pkg::EVT_SYN)
		&& (evt.event_code == iech_pkg::CODE_SYN_REPORT);

	assign slot_in_range = !evt.event_value[31]
		&& (evt.event_value[30:0] < 31'(TOUCH_SLOTS));

	assign hover_now = (|mask_q) || (dist_q && finger_q);

	always_comb begin
		notice.hit   = is_report && (hover_now != hovering_q);
		notice.kind  = iech_pkg::KIND_HOVER;
		notice.value = {1'b0, hover_now};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q       <= '0;
			slot_valid_q <= 1'b0;
			mask_q       <= '0;
			dist_q       <= 1'b0;
			finger_q     <= 1'b0;
			hovering_q   <= 1'b0;
		end else if (en) begin
			if (is_slot) begin
				slot_valid_q <= slot_in_range;
				// index kept on an out-of-range select
				if (slot_in_range) begin
					slot_q <= evt.event_value[SlotW-1:0];
				end
			end
			if (is_track && slot_valid_q) begin
				mask_q[slot_q] <= !evt.event_value[31];
			end
			if (is_dist) begin
				dist_q <= !evt.event_value[31] && (|evt.event_value[30:0]);
			end
			if (is_finger) begin
				finger_q <= (evt.event_value == 32'sd1);
			end
			if (is_report) begin
				hovering_q <= hover_now;
			end
		end
	end

endmodule

// ===== rtl/input_event_classifier_hover_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// input_event_classifier_hover_unit: input event classifier, top level
// Registers each event beat, decodes it against the switch and hover units,
// and holds any resulting notice in an output register.
// ----------------------------------------------------------------------------
// Timing: an accepted event waits in the input register; its notice, if any, is
//   captured in the notice register when that register is empty or being taken.
// Throughput: one event per cycle while the notice output is not stalled; set by
//   the single decode stage between the input register and the notice register.
// Reset: arst_n clears lid, tablet and hover state, the slot tracker and both
//   valid flags; the block takes events right after reset.
module input_event_classifier_hover_unit #(
	parameter int TOUCH_SLOTS = iech_pkg::TOUCH_SLOTS_DEF
) (
	input logic         clk,
	input logic         arst_n,
	iech_event_if.sink  evt,
	iech_notice_if.source notice
);

	logic              v_s1;
	iech_pkg::event_t  evt_s1;
	logic              advance;
	logic              proc_en;

	iech_pkg::notice_t sw_notice;
	iech_pkg::notice_t hov_notice;
	iech_pkg::notice_t sel_notice;
	logic              lid_now;
	logic              tablet_now;

	logic              out_v_q;
	logic [1:0]        kind_q;
	logic [1:0]        value_q;
	logic              lid_q;
	logic              tab_q;

	assign advance   = !out_v_q || notice.ready;
	assign proc_en   = v_s1 && advance;
	assign evt.ready = !v_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (evt.ready) begin
			v_s1 <= evt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (evt.valid && evt.ready) begin
			evt_s1.event_type         <= evt.event_type;
			evt_s1.event_code         <= evt.event_code;
			evt_s1.event_value        <= evt.event_value;
			evt_s1.from_power_button  <= evt.from_power_button;
			evt_s1.from_lid_switch    <= evt.from_lid_switch;
			evt_s1.from_tablet_switch <= evt.from_tablet_switch;
			evt_s1.from_hover_pad     <= evt.from_hover_pad;
		end
	end

	iech_switch u_switch (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (proc_en),
		.evt        (evt_s1),
		.notice     (sw_notice),
		.lid_now    (lid_now),
		.tablet_now (tablet_now)
	);

	iech_hover #(
		.TOUCH_SLOTS (TOUCH_SLOTS)
	) u_hover (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (proc_en),
		.evt    (evt_s1),
		.notice (hov_notice)
	);

	// switch and hover notices come from disjoint type/code pairs
	assign sel_notice = hov_notice.hit ? hov_notice : sw_notice;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (advance) begin
			out_v_q <= proc_en && sel_notice.hit;
		end
	end

	always_ff @(posedge clk) begin
		if (proc_en && sel_notice.hit) begin
			kind_q  <= sel_notice.kind;
			value_q <= sel_notice.value;
			lid_q   <= lid_now;
			tab_q   <= tablet_now;
		end
	end

	assign notice.valid          = out_v_q;
	assign notice.notice_kind    = kind_q;
	assign notice.notice_value   = value_q;
	assign notice.lid_closed_now = lid_q;
	assign notice.tablet_on_now  = tab_q;

	// only button notices carry a value of 2, and none carries 3
	assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q |-> (value_q != 2'd3)
			&& ((value_q != 2'd2) || (kind_q == iech_pkg::KIND_BUTTON)))
		else $error("notice value out of range for its kind");

	// a lid notice reports the same state it shows as kept
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && (kind_q == iech_pkg::KIND_LID)) |-> (lid_q == value_q[0]))
		else $error("lid notice disagrees with kept lid state");

	// a tablet notice reports the same state it shows as kept
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && (kind_q == iech_pkg::KIND_TABLET)) |-> (tab_q == value_q[0]))
		else $error("tablet notice disagrees with kept tablet state");

	// input side only stalls on an occupied stage behind a stalled notice
	assert property (@(posedge clk) disable iff (!arst_n)
		!evt.ready |-> (v_s1 && out_v_q && !notice.ready))
		else $error("input stalled without a blocked pipeline");

endmodule
